>>> hw/rtl/tsg_pkg.sv
// Shared types, constants and header word layout for the TCP SYN header generator.
`default_nettype none
package tsg_pkg;

  // Header geometry
  localparam int unsigned WORD_W      = 16;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned SUM_W       = 19;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Word positions within the 40-byte header
  localparam logic [IDX_W-1:0] WORD_VER_IHL   = 5'd0;
  localparam logic [IDX_W-1:0] WORD_TOT_LEN   = 5'd1;
  localparam logic [IDX_W-1:0] WORD_IDENT     = 5'd2;
  localparam logic [IDX_W-1:0] WORD_FRAG      = 5'd3;
  localparam logic [IDX_W-1:0] WORD_TTL_PROTO = 5'd4;
  localparam logic [IDX_W-1:0] WORD_IP_CSUM   = 5'd5;
  localparam logic [IDX_W-1:0] WORD_SRC_HI    = 5'd6;
  localparam logic [IDX_W-1:0] WORD_SRC_LO    = 5'd7;
  localparam logic [IDX_W-1:0] WORD_DST_HI    = 5'd8;
  localparam logic [IDX_W-1:0] WORD_DST_LO    = 5'd9;
  localparam logic [IDX_W-1:0] WORD_SPORT     = 5'd10;
  localparam logic [IDX_W-1:0] WORD_DPORT     = 5'd11;
  localparam logic [IDX_W-1:0] WORD_OFF_FLAGS = 5'd16;
  localparam logic [IDX_W-1:0] WORD_WINDOW    = 5'd17;
  localparam logic [IDX_W-1:0] WORD_TCP_CSUM  = 5'd18;
  localparam logic [IDX_W-1:0] WORD_LAST      = 5'd19;

  // Fixed header field values
  localparam logic [WORD_W-1:0] VAL_VER_IHL   = 16'h4500;
  localparam logic [WORD_W-1:0] VAL_TOT_LEN   = 16'd40;
  localparam logic [WORD_W-1:0] VAL_IDENT     = 16'd54321;
  localparam logic [WORD_W-1:0] VAL_TTL_PROTO = 16'h4006;
  localparam logic [WORD_W-1:0] VAL_PROTO     = 16'd6;
  localparam logic [WORD_W-1:0] VAL_TCP_LEN   = 16'd20;
  localparam logic [WORD_W-1:0] VAL_OFF_FLAGS = 16'h5002;
  localparam logic [WORD_W-1:0] VAL_WINDOW    = 16'd5840;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SOURCE_ADDRESS   = 1'b0,
    CFG_DESTINATION_PORT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [31:0] target_address;
    logic [15:0] origin_port;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]      header_word;
    logic [IDX_W-1:0] word_index;
    logic             last_word;
  } out_beat_t;

  // One classified request with both checksums done
  typedef struct packed {
    logic [31:0]       saddr;
    logic [31:0]       dst_addr;
    logic [15:0]       sport;
    logic [15:0]       dport;
    logic [WORD_W-1:0] ip_csum;
    logic [WORD_W-1:0] tcp_csum;
  } entry_t;

endpackage
`default_nettype wire

>>> hw/rtl/tsg_front.sv
// Front end: config registers, request intake and checksum computation.
`default_nettype none
module tsg_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tsg_pkg::in_beat_t in_beat_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output tsg_pkg::entry_t   push_entry_o
);
  import tsg_pkg::*;

  // Ones' complement fold with end-around carry, inverted
  function automatic logic [WORD_W-1:0] csum_fold(input logic [SUM_W-1:0] s);
    logic [WORD_W:0] f1;
    logic [WORD_W:0] f2;
    f1 = {{(WORD_W-2){1'b0}}, s[SUM_W-1:WORD_W]} + {1'b0, s[WORD_W-1:0]};
    f2 = {{WORD_W{1'b0}}, f1[WORD_W]} + {1'b0, f1[WORD_W-1:0]};
    return ~f2[WORD_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] ext(input logic [WORD_W-1:0] w);
    return {{(SUM_W-WORD_W){1'b0}}, w};
  endfunction

  logic [31:0] saddr_q;
  logic [15:0] dport_q;

  logic             stage_valid_q, stage_valid_d;
  logic [31:0]      st_dst_q;
  logic [15:0]      st_sport_q;
  logic [31:0]      st_src_q;
  logic [15:0]      st_dport_q;
  logic [SUM_W-1:0] ip_sum_q, ip_sum_d;
  logic [SUM_W-1:0] tcp_sum_q, tcp_sum_d;
  logic             accept;

  // Write config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saddr_q <= '0;
      dport_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SOURCE_ADDRESS:   saddr_q <= cfg_data_i;
        CFG_DESTINATION_PORT: dport_q <= cfg_data_i[15:0];
        default:              ;
      endcase
    end
  end

  assign in_ready_o = !stage_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Raw sums of all header words feeding each checksum
  always_comb begin
    ip_sum_d = ext(VAL_VER_IHL) + ext(VAL_TOT_LEN) + ext(VAL_IDENT) + ext(VAL_TTL_PROTO)
             + ext(saddr_q[31:16]) + ext(saddr_q[15:0])
             + ext(in_beat_i.target_address[31:16]) + ext(in_beat_i.target_address[15:0]);
    tcp_sum_d = ext(saddr_q[31:16]) + ext(saddr_q[15:0])
              + ext(in_beat_i.target_address[31:16]) + ext(in_beat_i.target_address[15:0])
              + ext(VAL_PROTO) + ext(VAL_TCP_LEN)
              + ext(in_beat_i.origin_port) + ext(dport_q)
              + ext(VAL_OFF_FLAGS) + ext(VAL_WINDOW);
  end

  always_comb begin
    stage_valid_d = stage_valid_q;
    if (accept) begin
      stage_valid_d = 1'b1;
    end else if (push_ready_i) begin
      stage_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else begin
      stage_valid_q <= stage_valid_d;
    end
  end

  // Capture the request and its sums
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_dst_q   <= in_beat_i.target_address;
      st_sport_q <= in_beat_i.origin_port;
      st_src_q   <= saddr_q;
      st_dport_q <= dport_q;
      ip_sum_q   <= ip_sum_d;
      tcp_sum_q  <= tcp_sum_d;
    end
  end

  // Fold and hand to the queue
  assign push_valid_o          = stage_valid_q;
  assign push_entry_o.saddr    = st_src_q;
  assign push_entry_o.dst_addr = st_dst_q;
  assign push_entry_o.sport    = st_sport_q;
  assign push_entry_o.dport    = st_dport_q;
  assign push_entry_o.ip_csum  = csum_fold(ip_sum_q);
  assign push_entry_o.tcp_csum = csum_fold(tcp_sum_q);

endmodule
`default_nettype wire

>>> hw/rtl/tsg_queue.sv
// Small FIFO of classified requests between front and back.
`default_nettype none
module tsg_queue #(
  parameter int unsigned Depth = tsg_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  tsg_pkg::entry_t push_entry_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output tsg_pkg::entry_t pop_entry_o
);
  import tsg_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntFull);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/tsg_back.sv
// Back end: word sequencer and registered output stage.
`default_nettype none
module tsg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  tsg_pkg::entry_t    pop_entry_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsg_pkg::out_beat_t out_beat_o
);
  import tsg_pkg::*;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  out_beat_t         out_q;
  logic [WORD_W-1:0] word;
  logic              load;

  // Select the header word at the current position
  always_comb begin
    case (idx_q)
      WORD_VER_IHL:   word = VAL_VER_IHL;
      WORD_TOT_LEN:   word = VAL_TOT_LEN;
      WORD_IDENT:     word = VAL_IDENT;
      WORD_TTL_PROTO: word = VAL_TTL_PROTO;
      WORD_IP_CSUM:   word = pop_entry_i.ip_csum;
      WORD_SRC_HI:    word = pop_entry_i.saddr[31:16];
      WORD_SRC_LO:    word = pop_entry_i.saddr[15:0];
      WORD_DST_HI:    word = pop_entry_i.dst_addr[31:16];
      WORD_DST_LO:    word = pop_entry_i.dst_addr[15:0];
      WORD_SPORT:     word = pop_entry_i.sport;
      WORD_DPORT:     word = pop_entry_i.dport;
      WORD_OFF_FLAGS: word = VAL_OFF_FLAGS;
      WORD_WINDOW:    word = VAL_WINDOW;
      WORD_TCP_CSUM:  word = pop_entry_i.tcp_csum;
      default:        word = '0;
    endcase
  end

  // Load a new beat whenever the output register is free
  assign load        = !out_valid_q || out_ready_i;
  assign pop_ready_o = load && (idx_q == WORD_LAST);

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = pop_valid_i;
      if (pop_valid_i) begin
        idx_d = (idx_q == WORD_LAST) ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && pop_valid_i) begin
      out_q.header_word <= word;
      out_q.word_index  <= idx_q;
      out_q.last_word   <= (idx_q == WORD_LAST);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule
`default_nettype wire

>>> hw/rtl/tcp_syn_header_generator.sv
// Top level of the TCP SYN header generator.
// Each request (destination address, source port) yields twenty 16-bit beats of
// an IPv4+TCP SYN header, word 0 first, with word_index 0..19 and last_word on
// word 19. The output channel moves one word a cycle while out_ready_i is high
// and a request is queued. The front end computes both checksums in one
// registered stage and pushes into a queue of QueueDepth requests, so it keeps
// taking requests while the back end streams words. Config writes take effect
// on the next accepted request; write them only while the block is idle.
`default_nettype none
module tcp_syn_header_generator #(
  parameter int unsigned QueueDepth = tsg_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tsg_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tsg_pkg::out_beat_t out_beat_o
);
  import tsg_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  tsg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_beat_i    (in_beat_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  tsg_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  tsg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_beat_o  (out_beat_o)
  );

  // Last flag marks exactly the final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.last_word == (out_beat_o.word_index == WORD_LAST)))
    else $error("last_word does not match word_index");

  // Word index stays within the header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_beat_o.word_index <= WORD_LAST))
    else $error("word_index out of range");

  // Words of one header come in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !out_beat_o.last_word) |=>
      (!out_valid_o || (out_beat_o.word_index == $past(out_beat_o.word_index) + 5'd1)))
    else $error("header words out of order");

  // The queue only pops on the final word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready) |=> (out_valid_o && out_beat_o.last_word))
    else $error("request retired before its last word");

endmodule
`default_nettype wire
